>>> sv/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// shared types and constants of the box mean filter
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_W_W    = 11;
	localparam int CFG_H_W    = 13;
	localparam int CFG_S_W    = 3;
	localparam int H_W        = 13;
	localparam int MAX_HEIGHT = 4096;

	localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [CFG_H_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [CFG_S_W-1:0] WINDOW_RST = 3'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic             frame_end;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FLUSH,
		ST_DLOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic setup;
		logic scan;
		logic dload;
		logic dstep;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic go;
		logic scan_last;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

>>> sv/bmf_ctrl.sv
// ----------------------------------------------------------------------------
// bmf_ctrl
// sequencer: item intake, window scan, divide and result hand-off
// ----------------------------------------------------------------------------
module bmf_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  bmf_pkg::sts_t sts,
	output bmf_pkg::cmd_t cmd
);
	import bmf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.go) begin
					cmd.setup = 1'b1;
					state_d   = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_DLOAD;
			end
			ST_DLOAD: begin
				cmd.dload = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.dstep = 1'b1;
				if (sts.div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/bmf_dp.sv
// ----------------------------------------------------------------------------
// bmf_dp
// datapath: config, line store, position counters, window sums, divider
// ----------------------------------------------------------------------------
module bmf_dp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  bmf_pkg::in_item_t                  in_item,
	input  bmf_pkg::cmd_t                      cmd,
	output bmf_pkg::sts_t                      sts,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bmf_pkg::out_item_t                 out_item
);
	import bmf_pkg::*;

	localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int W_W   = $clog2(MAX_WIDTH + 1);
	localparam int S_W   = $clog2(MAX_WINDOW + 1);
	localparam int N_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int SUM_W = PIX_W + N_W;
	localparam int LIN_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int DC_W  = $clog2(SUM_W);
	localparam logic signed [AW+1:0] DEPTH_S = (AW+2)'(DEPTH);

	// config registers
	logic [CFG_W_W-1:0] w_cfg_q;
	logic [CFG_H_W-1:0] h_cfg_q;
	logic [CFG_S_W-1:0] s_cfg_q;
	logic               restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q <= WIDTH_RST;
			h_cfg_q <= HEIGHT_RST;
			s_cfg_q <= WINDOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  w_cfg_q <= cfg_data[CFG_W_W-1:0];
				CFG_HEIGHT: h_cfg_q <= cfg_data[CFG_H_W-1:0];
				CFG_WINDOW: s_cfg_q <= cfg_data[CFG_S_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_valid && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
		cfg_index == CFG_WINDOW);

	// effective geometry
	logic [W_W-1:0]   eff_w;
	logic [H_W-1:0]   eff_h;
	logic [S_W-1:0]   eff_s, rad, dn;
	logic [LIN_W-1:0] total;

	always_comb begin
		if (w_cfg_q == '0) eff_w = W_W'(1);
		else if (int'(w_cfg_q) > MAX_WIDTH) eff_w = W_W'(MAX_WIDTH);
		else eff_w = W_W'(w_cfg_q);
		if (h_cfg_q == '0) eff_h = H_W'(1);
		else if (int'(h_cfg_q) > MAX_HEIGHT) eff_h = H_W'(MAX_HEIGHT);
		else eff_h = H_W'(h_cfg_q);
		if (s_cfg_q == '0) eff_s = S_W'(1);
		else if (int'(s_cfg_q) > MAX_WINDOW) eff_s = S_W'(MAX_WINDOW);
		else eff_s = S_W'(s_cfg_q);
		rad = eff_s >> 1;
		dn  = eff_s - S_W'(1) - rad;
	end

	assign total = LIN_W'(eff_w) * LIN_W'(eff_h);

	logic [LIN_W-1:0]      lag_q;
	logic [AW-1:0]         rlag_q;
	logic signed [AW+1:0]  step_q;

	always_ff @(posedge clk) begin
		lag_q  <= LIN_W'(dn) * LIN_W'(eff_w) + LIN_W'(dn);
		rlag_q <= AW'(rad) * AW'(eff_w) + AW'(rad);
		step_q <= $signed((AW+2)'(eff_w)) - $signed((AW+2)'(eff_s)) + (AW+2)'(1);
	end

	// input side
	logic [AW-1:0]    wp_q;
	logic [LIN_W-1:0] in_lin_q;
	logic             done_q;
	logic             wr_en;
	logic [LIN_W:0]   in_next;

	assign wr_en   = cmd.take && !in_item.action && !done_q;
	assign in_next = (LIN_W+1)'(in_lin_q) + (LIN_W+1)'(1);

	// output side counters
	logic [LIN_W-1:0] out_lin_q;
	logic [AW-1:0]    op_q;
	logic [H_W-1:0]   orow_q;
	logic [W_W-1:0]   ocol_q;
	logic [LIN_W:0]   out_next;
	logic             last;

	assign out_next = (LIN_W+1)'(out_lin_q) + (LIN_W+1)'(1);
	assign last     = out_next >= (LIN_W+1)'(total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			in_lin_q  <= '0;
			done_q    <= 1'b0;
			out_lin_q <= '0;
			op_q      <= '0;
			orow_q    <= '0;
			ocol_q    <= '0;
		end else if (restart || (cmd.emit && last)) begin
			wp_q      <= '0;
			in_lin_q  <= '0;
			done_q    <= 1'b0;
			out_lin_q <= '0;
			op_q      <= '0;
			orow_q    <= '0;
			ocol_q    <= '0;
		end else begin
			if (wr_en) begin
				wp_q     <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
				in_lin_q <= LIN_W'(in_next);
				if (in_next >= (LIN_W+1)'(total)) done_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_lin_q <= LIN_W'(out_next);
				op_q      <= (op_q == AW'(DEPTH - 1)) ? '0 : op_q + AW'(1);
				if (ocol_q == eff_w - W_W'(1)) begin
					ocol_q <= '0;
					orow_q <= orow_q + H_W'(1);
				end else begin
					ocol_q <= ocol_q + W_W'(1);
				end
			end
		end
	end

	assign sts.go = (out_lin_q < total) && (done_q ||
		((LIN_W+1)'(in_lin_q) >= (LIN_W+1)'(out_lin_q) + (LIN_W+1)'(lag_q) + (LIN_W+1)'(1)));

	// window scan
	logic [AW-1:0]        cell_q;
	logic [S_W-1:0]       cx_q, cy_q;
	logic signed [H_W:0]  yc_q;
	logic signed [W_W:0]  xc_q;
	logic signed [W_W:0]  x0;
	logic signed [AW+1:0] jump;
	logic [AW-1:0]        cell_next, start_addr;
	logic                 cell_in, row_end;

	assign x0      = $signed({1'b0, ocol_q}) - $signed((W_W+1)'(rad));
	assign row_end = cx_q == eff_s - S_W'(1);
	assign sts.scan_last = row_end && (cy_q == eff_s - S_W'(1));
	assign cell_in = !yc_q[H_W] && (yc_q < $signed({1'b0, eff_h})) &&
		!xc_q[W_W] && (xc_q < $signed({1'b0, eff_w}));
	assign start_addr = (op_q >= rlag_q) ? op_q - rlag_q : op_q + AW'(DEPTH) - rlag_q;

	always_comb begin
		jump = $signed({2'b00, cell_q}) + (row_end ? step_q : (AW+2)'(1));
		if (jump < 0) cell_next = AW'(jump + DEPTH_S);
		else if (jump >= DEPTH_S) cell_next = AW'(jump - DEPTH_S);
		else cell_next = AW'(jump);
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			cell_q <= start_addr;
			cx_q   <= '0;
			cy_q   <= '0;
			yc_q   <= $signed({1'b0, orow_q}) - $signed((H_W+1)'(rad));
			xc_q   <= x0;
		end else if (cmd.scan) begin
			cell_q <= cell_next;
			if (row_end) begin
				cx_q <= '0;
				cy_q <= cy_q + S_W'(1);
				yc_q <= yc_q + (H_W+1)'(1);
				xc_q <= x0;
			end else begin
				cx_q <= cx_q + S_W'(1);
				xc_q <= xc_q + (W_W+1)'(1);
			end
		end
	end

	// line store
	logic [3*PIX_W-1:0] mem [DEPTH];
	logic [3*PIX_W-1:0] rd_s1;
	logic               rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wp_q] <= {in_item.red_in, in_item.green_in, in_item.blue_in};
		if (cmd.scan) rd_s1 <= mem[cell_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_s1 <= 1'b0;
		else rd_vld_s1 <= cmd.scan && cell_in;
	end

	// accumulate and divide, one lane per channel
	logic [SUM_W-1:0] acc_q [3];
	logic [N_W-1:0]   n_q;
	logic [N_W-1:0]   rem_q [3];
	logic [SUM_W-1:0] quo_q [3];
	logic [N_W+1:0]   diff [3];
	logic [DC_W-1:0]  dcnt_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {1'b0, rem_q[i], quo_q[i][SUM_W-1]} - (N_W+2)'(n_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			n_q <= '0;
		end else if (rd_vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= acc_q[i] + SUM_W'(rd_s1[3*PIX_W-1-PIX_W*i -: PIX_W]);
			end
			n_q <= n_q + N_W'(1);
		end
		if (cmd.dload) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= acc_q[i];
			end
			dcnt_q <= '0;
		end else if (cmd.dstep) begin
			for (int i = 0; i < 3; i++) begin
				if (diff[i][N_W+1]) begin
					rem_q[i] <= {rem_q[i][N_W-2:0], quo_q[i][SUM_W-1]};
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b0};
				end else begin
					rem_q[i] <= diff[i][N_W-1:0];
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b1};
				end
			end
			dcnt_q <= dcnt_q + DC_W'(1);
		end
	end

	assign sts.div_last = dcnt_q == DC_W'(SUM_W - 1);

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.red_out   <= quo_q[0][PIX_W-1:0];
			out_q.green_out <= quo_q[1][PIX_W-1:0];
			out_q.blue_out  <= quo_q[2][PIX_W-1:0];
			out_q.frame_end <= last;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_item     = out_q;

endmodule

>>> sv/box_mean_filter_core.sv
// ----------------------------------------------------------------------------
// box_mean_filter_core
// border-normalized box mean filter on a raster rgb pixel stream
// ----------------------------------------------------------------------------
// Handles one item at a time. An item that yields no result is taken, checked
// and sent back to idle; one that yields a result is also scanned, divided
// and emitted: the window is read from the line store one pixel per cycle,
// then the three channel sums go through a one-bit-per-cycle restoring
// divider. A finished result waits in an output register while the next
// item is taken. A configuration write to the width, height or window
// register restarts the frame.
// ----------------------------------------------------------------------------
module box_mean_filter_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bmf_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bmf_pkg::out_item_t             out_item
);
	import bmf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmf_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
